@@ design/vlms_pkg.sv @@
`timescale 1ns / 1ps

package vlms_pkg;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] place_x;
    logic signed [31:0] place_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               was_limited;
  } out_t;

  typedef enum logic {
    ITER_SQRT,
    ITER_DIV
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_ctl_t;

  localparam logic [1:0] CFG_LIMIT_ENABLE = 2'd0;
  localparam logic [1:0] CFG_X_LIMIT      = 2'd1;
  localparam logic [1:0] CFG_Y_LIMIT      = 2'd2;
  localparam logic [1:0] CFG_TOTAL_LIMIT  = 2'd3;

  localparam int EN_X     = 0;
  localparam int EN_Y     = 1;
  localparam int EN_TOTAL = 2;

  localparam logic       OP_TICK  = 1'b0;
  localparam logic       OP_PLACE = 1'b1;

  localparam logic signed [31:0] SMAX32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN32 = 32'sh8000_0000;

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? SMIN32 : SMAX32;
    end
    return s[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

@@ design/vlms_mul.sv @@
`timescale 1ns / 1ps

module vlms_mul import vlms_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_r;

endmodule

@@ design/vlms_iter.sv @@
`timescale 1ns / 1ps

module vlms_iter import vlms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  iter_ctl_t   ctl_i,
  input  logic [63:0] opnd_i,
  input  logic [31:0] dvsr_i,
  output logic        done_o,
  output logic [31:0] result_o
);

  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd31;

  logic        busy_r;
  logic        done_r;
  iter_mode_t  mode_r;
  logic [5:0]  cnt_r;
  logic [32:0] rem_r;
  logic [31:0] acc_r;
  logic [63:0] src_r;
  logic [31:0] dvsr_r;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic [34:0] diff;
  logic        ge;

  // Square root and long division share one compare-subtract step.
  always_comb begin
    if (mode_r == ITER_SQRT) begin
      rem_sh = {rem_r, src_r[63:62]};
      trial  = {1'b0, acc_r, 2'b01};
    end else begin
      rem_sh = {2'b00, rem_r[31:0], src_r[63]};
      trial  = {3'b000, dvsr_r};
    end
    ge   = (rem_sh >= trial);
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (ctl_i.start) begin
        done_r <= 1'b0;
        busy_r <= 1'b1;
        mode_r <= ctl_i.mode;
        acc_r  <= '0;
        dvsr_r <= dvsr_i;
        if (ctl_i.mode == ITER_SQRT) begin
          rem_r <= '0;
          src_r <= opnd_i;
          cnt_r <= SQRT_STEPS;
        end else begin
          rem_r <= {1'b0, opnd_i[62:31]};
          src_r <= {opnd_i[30:0], 33'd0};
          cnt_r <= DIV_STEPS;
        end
      end else if (busy_r) begin
        rem_r  <= ge ? diff[32:0] : rem_sh[32:0];
        acc_r  <= {acc_r[30:0], ge};
        src_r  <= (mode_r == ITER_SQRT) ? {src_r[61:0], 2'b00} : {src_r[62:0], 1'b0};
        cnt_r  <= cnt_r - 6'd1;
        done_r <= (cnt_r == 6'd1);
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done_o   = done_r;
  assign result_o = acc_r;

endmodule

@@ design/velocity_limited_motion_step_unit.sv @@
`timescale 1ns / 1ps

// Two-dimensional Euler motion step on signed Q16.16 values with per-axis and
// total speed limits. One item is in work at a time; in_ready is high only
// while the sequencer is idle, and a finished result waits in the output
// register while the next item is taken. A place item goes straight to the
// result; a tick first applies the per-axis clamps and, with the total limit
// enabled, compares the squared speed with the squared limit. When the speed
// is over the limit the vector is rescaled: the shared compare-subtract unit
// takes the square root of the squared speed and then each of the two
// quotients, and one registered 32 by 32 multiplier forms the squares and the
// products in turn.
module velocity_limited_motion_step_unit import vlms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [30:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_L,
    ST_CMP,
    ST_SQRT,
    ST_MULQ_X,
    ST_DIV_X_GO,
    ST_DIV_X,
    ST_MULQ_Y,
    ST_DIV_Y_GO,
    ST_DIV_Y,
    ST_DONE
  } state_t;

  state_t state_r;

  logic [2:0]  en_r;
  logic [30:0] xlim_r;
  logic [30:0] ylim_r;
  logic [30:0] tlim_r;

  logic signed [31:0] posx_r;
  logic signed [31:0] posy_r;
  logic signed [31:0] velx_r;
  logic signed [31:0] vely_r;

  logic               op_r;
  logic signed [31:0] placex_r;
  logic signed [31:0] placey_r;
  logic signed [31:0] vx_r;
  logic signed [31:0] vy_r;
  logic               hit_r;
  logic [63:0]        sq_r;
  logic [31:0]        m_r;

  logic               out_valid_r;
  out_t               out_data_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  iter_ctl_t   iter_ctl;
  logic [63:0] iter_opnd;
  logic        iter_done;
  logic [31:0] iter_q;

  logic signed [31:0] xlim_s;
  logic signed [31:0] ylim_s;
  logic signed [31:0] cvx;
  logic signed [31:0] cvy;
  logic               chit;
  logic signed [31:0] q_s;
  logic signed [31:0] newpx;
  logic signed [31:0] newpy;

  vlms_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  vlms_iter u_iter (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (iter_ctl),
    .opnd_i   (iter_opnd),
    .dvsr_i   (m_r),
    .done_o   (iter_done),
    .result_o (iter_q)
  );

  always_comb begin
    case (state_r)
      ST_MUL_X: begin
        mul_a = mag32(vx_r);
        mul_b = mag32(vx_r);
      end
      ST_MUL_Y: begin
        mul_a = mag32(vy_r);
        mul_b = mag32(vy_r);
      end
      ST_MUL_L: begin
        mul_a = {1'b0, tlim_r};
        mul_b = {1'b0, tlim_r};
      end
      ST_MULQ_X: begin
        mul_a = mag32(vx_r);
        mul_b = {1'b0, tlim_r};
      end
      ST_MULQ_Y: begin
        mul_a = mag32(vy_r);
        mul_b = {1'b0, tlim_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    iter_ctl.start = 1'b0;
    iter_ctl.mode  = ITER_DIV;
    iter_opnd      = mul_p;
    case (state_r)
      ST_CMP: begin
        iter_ctl.start = (sq_r > mul_p);
        iter_ctl.mode  = ITER_SQRT;
        iter_opnd      = sq_r;
      end
      ST_DIV_X_GO,
      ST_DIV_Y_GO: begin
        iter_ctl.start = 1'b1;
      end
      default: begin
        iter_ctl.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    xlim_s = signed'({1'b0, xlim_r});
    ylim_s = signed'({1'b0, ylim_r});
    cvx    = vx_r;
    cvy    = vy_r;
    chit   = 1'b0;
    if (en_r[EN_X] && (mag32(vx_r) > {1'b0, xlim_r})) begin
      cvx  = vx_r[31] ? -xlim_s : xlim_s;
      chit = 1'b1;
    end
    if (en_r[EN_Y] && (mag32(vy_r) > {1'b0, ylim_r})) begin
      cvy  = vy_r[31] ? -ylim_s : ylim_s;
      chit = 1'b1;
    end
    q_s   = signed'(iter_q);
    newpx = sat_add32(posx_r, vx_r);
    newpy = sat_add32(posy_r, vy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= '0;
      xlim_r <= '0;
      ylim_r <= '0;
      tlim_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LIMIT_ENABLE: en_r   <= cfg_wdata[2:0];
        CFG_X_LIMIT:      xlim_r <= cfg_wdata;
        CFG_Y_LIMIT:      ylim_r <= cfg_wdata;
        CFG_TOTAL_LIMIT:  tlim_r <= cfg_wdata;
        default:          en_r   <= en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      posx_r      <= '0;
      posy_r      <= '0;
      velx_r      <= '0;
      vely_r      <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r     <= in_data.operation;
            placex_r <= in_data.place_x;
            placey_r <= in_data.place_y;
            vx_r     <= sat_add32(velx_r, in_data.accel_x);
            vy_r     <= sat_add32(vely_r, in_data.accel_y);
            hit_r    <= 1'b0;
            state_r  <= (in_data.operation == OP_PLACE) ? ST_DONE : ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          vx_r    <= cvx;
          vy_r    <= cvy;
          hit_r   <= chit;
          state_r <= en_r[EN_TOTAL] ? ST_MUL_X : ST_DONE;
        end
        ST_MUL_X: begin
          state_r <= ST_MUL_Y;
        end
        ST_MUL_Y: begin
          sq_r    <= mul_p;
          state_r <= ST_MUL_L;
        end
        ST_MUL_L: begin
          sq_r    <= sq_r + mul_p;
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (sq_r > mul_p) begin
            hit_r   <= 1'b1;
            state_r <= ST_SQRT;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_SQRT: begin
          if (iter_done) begin
            m_r     <= iter_q;
            state_r <= ST_MULQ_X;
          end
        end
        ST_MULQ_X: begin
          state_r <= ST_DIV_X_GO;
        end
        ST_DIV_X_GO: begin
          state_r <= ST_DIV_X;
        end
        ST_DIV_X: begin
          if (iter_done) begin
            vx_r    <= vx_r[31] ? -q_s : q_s;
            state_r <= ST_MULQ_Y;
          end
        end
        ST_MULQ_Y: begin
          state_r <= ST_DIV_Y_GO;
        end
        ST_DIV_Y_GO: begin
          state_r <= ST_DIV_Y;
        end
        ST_DIV_Y: begin
          if (iter_done) begin
            vy_r    <= vy_r[31] ? -q_s : q_s;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
            if (op_r == OP_PLACE) begin
              posx_r     <= placex_r;
              posy_r     <= placey_r;
              velx_r     <= '0;
              vely_r     <= '0;
              out_data_r <= '{pos_x: placex_r, pos_y: placey_r, vel_x: '0, vel_y: '0,
                              was_limited: 1'b0};
            end else begin
              posx_r     <= newpx;
              posy_r     <= newpy;
              velx_r     <= vx_r;
              vely_r     <= vy_r;
              out_data_r <= '{pos_x: newpx, pos_y: newpy, vel_x: vx_r, vel_y: vy_r,
                              was_limited: hit_r};
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/tb_velocity_limited_motion_step_unit.sv @@
`timescale 1ns / 1ps

module tb_velocity_limited_motion_step_unit;
  import vlms_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned MAX_REPORTS = 40;
  localparam int unsigned RANDOM_PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 200;

  localparam int unsigned SPREAD_FULL = 0;
  localparam int unsigned SPREAD_NEAR = 1;
  localparam int unsigned SPREAD_EDGE = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_LIMIT_ENABLE;
  logic [30:0] cfg_wdata = '0;

  velocity_limited_motion_step_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mirror of the limit registers and the motion state.
  logic [2:0]         enable_m = '0;
  logic [30:0]        x_limit_m = '0;
  logic [30:0]        y_limit_m = '0;
  logic [30:0]        total_limit_m = '0;
  logic signed [31:0] pos_x_m = '0;
  logic signed [31:0] pos_y_m = '0;
  logic signed [31:0] vel_x_m = '0;
  logic signed [31:0] vel_y_m = '0;

  out_t expected_q[$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned limited_seen = 0;
  int unsigned place_sent = 0;
  int unsigned tick_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic void axis_limit(inout logic signed [63:0] v, input logic [30:0] lim,
                                     inout logic hit);
    logic signed [63:0] l;
    l = {33'd0, lim};
    if (((v < 0) ? -v : v) > l) begin
      hit = 1'b1;
      v = (v < 0) ? -l : l;
    end
  endfunction

  function automatic logic signed [63:0] shrink_comp(input logic signed [63:0] v,
                                                     input logic [30:0] lim,
                                                     input logic [63:0] root);
    logic [63:0] a;
    logic [63:0] q;
    a = (v < 0) ? -v : v;
    q = (a * {33'd0, lim}) / root;
    return (v < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic out_t predict_motion(input in_t item);
    out_t               res;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] p;
    logic [63:0]        ax;
    logic [63:0]        ay;
    logic [63:0]        sq;
    logic [63:0]        lim_sq;
    logic [63:0]        root;
    logic               hit;
    hit = 1'b0;
    if (item.operation == OP_PLACE) begin
      pos_x_m = item.place_x;
      pos_y_m = item.place_y;
      vel_x_m = '0;
      vel_y_m = '0;
    end else begin
      vx = vel_x_m;
      vx = clip32(vx + $signed(item.accel_x));
      vy = vel_y_m;
      vy = clip32(vy + $signed(item.accel_y));
      if (enable_m[EN_X]) begin
        axis_limit(vx, x_limit_m, hit);
      end
      if (enable_m[EN_Y]) begin
        axis_limit(vy, y_limit_m, hit);
      end
      if (enable_m[EN_TOTAL]) begin
        ax = (vx < 0) ? -vx : vx;
        ay = (vy < 0) ? -vy : vy;
        sq = ax * ax + ay * ay;
        lim_sq = {33'd0, total_limit_m} * {33'd0, total_limit_m};
        if (sq > lim_sq) begin
          hit = 1'b1;
          root = floor_sqrt(sq);
          if (root != 0) begin
            vx = shrink_comp(vx, total_limit_m, root);
            vy = shrink_comp(vy, total_limit_m, root);
          end
        end
      end
      vel_x_m = vx[31:0];
      vel_y_m = vy[31:0];
      p = pos_x_m;
      p = clip32(p + vx);
      pos_x_m = p[31:0];
      p = pos_y_m;
      p = clip32(p + vy);
      pos_y_m = p[31:0];
    end
    res.pos_x = pos_x_m;
    res.pos_y = pos_y_m;
    res.vel_x = vel_x_m;
    res.vel_y = vel_y_m;
    res.was_limited = hit;
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value(input int unsigned spread);
    logic [31:0] u;
    case (spread)
      SPREAD_FULL: u = $urandom;
      SPREAD_NEAR: u = $urandom_range(0, 32'h7FFFF) - 32'h40000;
      default: begin
        case ($urandom_range(0, 4))
          0: u = 32'h7FFF_FFFF;
          1: u = 32'h8000_0000;
          2: u = 32'h0;
          3: u = 32'h1;
          default: u = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return u;
  endfunction

  function automatic int unsigned pick_spread();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return SPREAD_NEAR;
    end
    return (r < 9) ? SPREAD_FULL : SPREAD_EDGE;
  endfunction

  function automatic logic [30:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(0, 32'h80000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic in_t random_item();
    in_t it;
    it.operation = ($urandom_range(0, 99) < 8) ? OP_PLACE : OP_TICK;
    it.accel_x = pick_value(pick_spread());
    it.accel_y = pick_value(pick_spread());
    it.place_x = pick_value(pick_spread());
    it.place_y = pick_value(pick_spread());
    return it;
  endfunction

  function automatic in_t place_item(input logic signed [31:0] x, input logic signed [31:0] y);
    in_t it;
    it.operation = OP_PLACE;
    it.accel_x = $urandom;
    it.accel_y = $urandom;
    it.place_x = x;
    it.place_y = y;
    return it;
  endfunction

  function automatic in_t tick_item(input logic signed [31:0] ax, input logic signed [31:0] ay);
    in_t it;
    it.operation = OP_TICK;
    it.accel_x = ax;
    it.accel_y = ay;
    it.place_x = $urandom;
    it.place_y = $urandom;
    return it;
  endfunction

  // Returns right after the transfer edge with valid still high, so a following
  // call can present its item in the same step.
  task automatic send_item(input in_t item);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do begin
      @(posedge clk);
    end while (!in_ready);
    expected_q.push_back(predict_motion(item));
    if (item.operation == OP_PLACE) begin
      place_sent++;
    end else begin
      tick_sent++;
    end
  endtask

  task automatic wait_for_results(input int unsigned tail);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_limits(input logic [2:0] en, input logic [30:0] xl,
                            input logic [30:0] yl, input logic [30:0] tl);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_LIMIT_ENABLE;
    cfg_wdata <= {28'd0, en};
    @(posedge clk);
    cfg_idx <= CFG_X_LIMIT;
    cfg_wdata <= xl;
    @(posedge clk);
    cfg_idx <= CFG_Y_LIMIT;
    cfg_wdata <= yl;
    @(posedge clk);
    cfg_idx <= CFG_TOTAL_LIMIT;
    cfg_wdata <= tl;
    @(posedge clk);
    cfg_we <= 1'b0;
    enable_m = en;
    x_limit_m = xl;
    y_limit_m = yl;
    total_limit_m = tl;
    settings_used++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("Mismatch at result %0d: %s got %h expected %h",
               results_seen, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending, pos_x", out_data.pos_x, '0);
      end else begin
        want = expected_q.pop_front();
        if (want.was_limited) begin
          limited_seen++;
        end
        if (out_data.pos_x !== want.pos_x) begin
          report_mismatch("pos_x", out_data.pos_x, want.pos_x);
        end
        if (out_data.pos_y !== want.pos_y) begin
          report_mismatch("pos_y", out_data.pos_y, want.pos_y);
        end
        if (out_data.vel_x !== want.vel_x) begin
          report_mismatch("vel_x", out_data.vel_x, want.vel_x);
        end
        if (out_data.vel_y !== want.vel_y) begin
          report_mismatch("vel_y", out_data.vel_y, want.vel_y);
        end
        if (out_data.was_limited !== want.was_limited) begin
          report_mismatch("was_limited", {31'd0, out_data.was_limited},
                          {31'd0, want.was_limited});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = holds_served + 1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_place_extremes();
    set_limits(3'd0, '0, '0, '0);
    send_item(place_item(SMAX32, SMIN32));
    send_item(place_item(SMIN32, SMAX32));
    send_item(place_item(32'sd0, 32'sd0));
    send_item(place_item(-32'sd1, 32'sd1));
    wait_for_results(4);
  endtask

  // Velocity runs into saturation in each direction, position at the positive end.
  task automatic test_free_motion();
    send_item(place_item(32'sd0, 32'sd0));
    send_item(tick_item(SMAX32, SMAX32));
    send_item(tick_item(SMAX32, SMAX32));
    send_item(tick_item(SMIN32, SMIN32));
    send_item(tick_item(SMIN32, SMIN32));
    wait_for_results(4);
  endtask

  task automatic test_axis_clamp();
    set_limits(3'd3, 31'h30000, 31'h7FFF_FFFF, '0);
    send_item(place_item(32'sd0, 32'sd0));
    send_item(tick_item(32'sh50000, SMIN32));
    send_item(tick_item(-32'sh A0000, 32'sd0));
    wait_for_results(4);
    set_limits(3'd1, '0, '0, '0);
    send_item(tick_item(32'sd1, 32'sd1));
    send_item(tick_item(-32'sd1, -32'sd1));
    wait_for_results(4);
  endtask

  task automatic test_speed_rescale();
    set_limits(3'd4, '0, '0, 31'h10000);
    send_item(place_item(32'sd0, 32'sd0));
    send_item(tick_item(32'sh10000, 32'sd0));
    send_item(tick_item(32'sh8000, 32'sh10000));
    send_item(tick_item(SMIN32, SMAX32));
    wait_for_results(4);
    // The flag is raised even though the rescaled velocity equals the old one.
    set_limits(3'd4, '0, '0, 31'd1);
    send_item(place_item(32'sd0, 32'sd0));
    send_item(tick_item(32'sd1, 32'sd1));
    wait_for_results(4);
    set_limits(3'd4, '0, '0, '0);
    send_item(tick_item(32'sd5, -32'sd3));
    wait_for_results(4);
    set_limits(3'd7, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(place_item(32'sd0, 32'sd0));
    send_item(tick_item(SMIN32, SMIN32));
    send_item(tick_item(SMAX32, SMAX32));
    wait_for_results(4);
  endtask

  task automatic test_output_backpressure();
    set_limits(3'd4, '0, '0, 31'h8000);
    hold_requests++;
    for (int i = 0; i < 12; i++) begin
      send_item(tick_item(pick_value(SPREAD_NEAR), pick_value(SPREAD_NEAR)));
    end
    wait_for_results(4);
  endtask

  task automatic test_random_settings();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_limits(3'd7, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        1: set_limits(3'd7, 31'h20000, 31'h28000, 31'h30000);
        2: set_limits(3'd0, '0, '0, '0);
        default: set_limits(3'($urandom_range(0, 7)), pick_limit(), pick_limit(), pick_limit());
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(random_item());
      end
      wait_for_results(4);
    end
  endtask

  task automatic test_random_steady();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_limits(3'd7, 31'($urandom_range(0, 32'h80000)), 31'($urandom_range(0, 32'h80000)),
               31'($urandom_range(0, 32'h80000)));
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      send_item(random_item());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_place_extremes();
    test_free_motion();
    test_axis_clamp();
    test_speed_rescale();
    test_output_backpressure();
    test_random_settings();
    test_random_steady();
    wait_for_results(SETTLE_CYCLES);
    $display("Sent %0d tick and %0d place transfers across %0d limit settings.",
             tick_sent, place_sent, settings_used);
    $display("Checked %0d results, %0d of them speed-limited, with %0d mismatches.",
             results_seen, limited_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
